>>> hdl/vwrgb_pkg.sv
// ----------------------------------------------------------------------------
// vwrgb_pkg
// Shared types, constants and palette tables for the video word expander.
// ----------------------------------------------------------------------------
package vwrgb_pkg;

    localparam int WORD_W        = 16;
    localparam int PIX_W         = 32;
    localparam int ADDR_W        = 14;
    localparam int LINE_W        = 8;
    localparam int COL_W         = 5;
    localparam int PIX_IDX_W     = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 10;
    localparam int SCROLL_W      = 10;
    localparam int PAL_NUM_W     = 4;

    localparam logic [LINE_W-1:0] SCROLL_WRAP  = 8'o330;
    localparam logic [LINE_W-1:0] SCROLL_BIAS  = 8'o050;
    localparam int                FULL_BIT     = 9;

    localparam logic [PIX_W-1:0] BLACK_ARGB = 32'hFF000000;
    localparam logic [PIX_W-1:0] WHITE_ARGB = 32'hFFFFFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MACHINE_EXT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_NUM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_PORT = 3'd3;

    typedef struct packed {
        logic                  color_mode;
        logic                  machine_extended;
        logic [PAL_NUM_W-1:0]  palette_number;
        logic [SCROLL_W-1:0]   scroll_port;
    } t_cfg;

    localparam logic [PIX_W-1:0] BASE_PAL [0:3] = '{
        32'hFF000000, 32'hFF0000FF, 32'hFF00FF00, 32'hFFFF0000
    };

    localparam logic [PIX_W-1:0] EXT_PAL [0:15][0:3] = '{
        '{32'hFF000000, 32'hFF0000FF, 32'hFF00FF00, 32'hFFFF0000},
        '{32'hFF000000, 32'hFFFFFF00, 32'hFFFF00FF, 32'hFFFF0000},
        '{32'hFF000000, 32'hFF00FFFF, 32'hFF0000FF, 32'hFFFF00FF},
        '{32'hFF000000, 32'hFF00FF00, 32'hFF00FFFF, 32'hFFFFFF00},
        '{32'hFF000000, 32'hFFFF00FF, 32'hFF00FFFF, 32'hFFFFFFFF},
        '{32'hFF000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
        '{32'hFF000000, 32'hFFC00000, 32'hFF8E0000, 32'hFFFF0000},
        '{32'hFF000000, 32'hFFC0FF00, 32'hFF8EFF00, 32'hFFFFFF00},
        '{32'hFF000000, 32'hFFC000FF, 32'hFF8E00FF, 32'hFFFF00FF},
        '{32'hFF000000, 32'hFF8EFF00, 32'hFF8E00FF, 32'hFF8E0000},
        '{32'hFF000000, 32'hFFC0FF00, 32'hFFC000FF, 32'hFFC00000},
        '{32'hFF000000, 32'hFF00FFFF, 32'hFFFFFF00, 32'hFFFF0000},
        '{32'hFF000000, 32'hFFFF0000, 32'hFF00FF00, 32'hFF00FFFF},
        '{32'hFF000000, 32'hFF00FFFF, 32'hFFFFFF00, 32'hFFFFFFFF},
        '{32'hFF000000, 32'hFFFFFF00, 32'hFF00FF00, 32'hFFFFFFFF},
        '{32'hFF000000, 32'hFF00FFFF, 32'hFF00FF00, 32'hFFFFFFFF}
    };

    function automatic logic [PIX_W-1:0] pal_color(
        input logic                 ext,
        input logic [PAL_NUM_W-1:0] num,
        input logic [1:0]           idx
    );
        logic [PIX_W-1:0] c;
        if (ext) begin
            c = EXT_PAL[num][idx];
        end else begin
            c = BASE_PAL[idx];
        end
        return c;
    endfunction

endpackage

>>> hdl/vwrgb_if.sv
// ----------------------------------------------------------------------------
// vwrgb_if
// Valid/ready channels for video words in and pixel beats out.
// ----------------------------------------------------------------------------
interface vwrgb_word_if;
    import vwrgb_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] video_word;

    modport source (output valid, output video_word, input ready);
    modport sink   (input valid, input video_word, output ready);
endinterface

interface vwrgb_pix_if;
    import vwrgb_pkg::*;

    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  pixel_argb;
    logic              last_of_word;
    logic [ADDR_W-1:0] next_fetch_addr;

    modport source (output valid, output pixel_argb, output last_of_word,
                    output next_fetch_addr, input ready);
    modport sink   (input valid, input pixel_argb, input last_of_word,
                    input next_fetch_addr, output ready);
endinterface

>>> hdl/video_word_to_rgb_pixels.sv
// ----------------------------------------------------------------------------
// video_word_to_rgb_pixels
// Expands 16-bit video words into ARGB pixel beats, least significant bit first.
//
// Input channel i_word carries one video word per beat in raster order,
// 32 words per line, 256 lines per frame. Output channel o_pix carries 16
// pixel beats per word; the sixteenth has last_of_word set, and every beat
// carries the byte address of the next word to fetch (scroll applied).
// The configuration port writes color mode, machine type, palette number
// and the raw scroll port; write it only while no word is in flight.
// A word is held in an expansion register and drained one pixel per cycle,
// while the receiver is ready, into the output register; the first pixel
// beat passes through the expansion register and then the output register.
// The next word can be taken in the same cycle that the last pixel of the
// previous word is loaded into the output register.
// Reset clears the line and column counters, empties both registers and
// loads the register defaults. A stalled receiver holds the output beat and,
// once the expansion register is full, holds off the input channel.
// ----------------------------------------------------------------------------
module video_word_to_rgb_pixels
    import vwrgb_pkg::*;
#(
    parameter int SMALL_LINES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vwrgb_word_if.sink            i_word,
    vwrgb_pix_if.source           o_pix
);

    localparam logic [LINE_W:0] SMALL_LIMIT = (LINE_W+1)'(SMALL_LINES);

    t_cfg                 r_cfg;
    logic [LINE_W-1:0]    r_line;
    logic [COL_W-1:0]     r_col;
    logic [LINE_W-1:0]    n_line;
    logic [COL_W-1:0]     n_col;
    logic [LINE_W-1:0]    scroll_raw;
    logic [LINE_W-1:0]    scroll_eff;
    logic [LINE_W-1:0]    mem_line;
    logic [ADDR_W-1:0]    n_addr;
    logic                 n_blank;

    logic                 r_busy;
    logic [WORD_W-1:0]    r_word;
    logic                 r_blank;
    logic [ADDR_W-1:0]    r_addr;
    logic [PIX_IDX_W-1:0] r_k;

    logic                 r_ov;
    logic [PIX_W-1:0]     r_px;
    logic                 r_last;
    logic [ADDR_W-1:0]    r_oaddr;

    logic                 accept;
    logic                 load;
    logic                 last_k;
    logic [PIX_W-1:0]     pixel;

    // counters and fetch address for the word being accepted
    always_comb begin
        n_col      = r_col + 1'b1;
        n_line     = (r_col == '1) ? r_line + 1'b1 : r_line;
        scroll_raw = r_cfg.scroll_port[LINE_W-1:0];
        scroll_eff = (scroll_raw >= SCROLL_WRAP) ? scroll_raw - SCROLL_WRAP
                                                 : scroll_raw + SCROLL_BIAS;
        mem_line   = n_line + scroll_eff;
        n_addr     = {mem_line, n_col, 1'b0};
        n_blank    = !r_cfg.scroll_port[FULL_BIT] && ({1'b0, r_line} >= SMALL_LIMIT);
    end

    assign last_k       = (r_k == '1);
    assign load         = r_busy && (!r_ov || o_pix.ready);
    assign i_word.ready = !r_busy || (load && last_k);
    assign accept       = i_word.valid && i_word.ready;

    vwrgb_pixel_lut u_lut (
        .i_cfg   (r_cfg),
        .i_word  (r_word),
        .i_idx   (r_k),
        .i_blank (r_blank),
        .o_pixel (pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode       <= 1'b1;
            r_cfg.machine_extended <= 1'b0;
            r_cfg.palette_number   <= '0;
            r_cfg.scroll_port      <= SCROLL_W'(512);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLOR_MODE:  r_cfg.color_mode       <= i_cfg_data[0];
                CFG_MACHINE_EXT: r_cfg.machine_extended <= i_cfg_data[0];
                CFG_PALETTE_NUM: r_cfg.palette_number   <= i_cfg_data[PAL_NUM_W-1:0];
                CFG_SCROLL_PORT: r_cfg.scroll_port      <= i_cfg_data[SCROLL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_col  <= '0;
            r_busy <= 1'b0;
            r_k    <= '0;
        end else begin
            if (accept) begin
                r_line <= n_line;
                r_col  <= n_col;
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (load) begin
                r_k <= r_k + 1'b1;
                if (last_k) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word  <= i_word.video_word;
            r_blank <= n_blank;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (o_pix.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px    <= pixel;
            r_last  <= last_k;
            r_oaddr <= r_addr;
        end
    end

    assign o_pix.valid           = r_ov;
    assign o_pix.pixel_argb      = r_px;
    assign o_pix.last_of_word    = r_last;
    assign o_pix.next_fetch_addr = r_oaddr;

`ifndef SYNTHESIS
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_k == '0)
        else $error("pixel index moved with no word held");

    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!r_busy || (last_k && load)))
        else $error("word accepted over a word still expanding");

    a_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.last_of_word) |-> r_busy)
        else $error("word dropped before its last pixel");
`endif

endmodule

>>> hdl/vwrgb_pixel_lut.sv
// ----------------------------------------------------------------------------
// vwrgb_pixel_lut
// Pixel color for one position of a video word: mono, palette or blank.
// ----------------------------------------------------------------------------
module vwrgb_pixel_lut
    import vwrgb_pkg::*;
(
    input  t_cfg                 i_cfg,
    input  logic [WORD_W-1:0]    i_word,
    input  logic [PIX_IDX_W-1:0] i_idx,
    input  logic                 i_blank,
    output logic [PIX_W-1:0]     o_pixel
);

    logic [1:0] pair;

    assign pair = i_word[{i_idx[PIX_IDX_W-1:1], 1'b0} +: 2];

    always_comb begin
        if (i_blank) begin
            o_pixel = BLACK_ARGB;
        end else if (i_cfg.color_mode) begin
            o_pixel = pal_color(i_cfg.machine_extended, i_cfg.palette_number, pair);
        end else if (i_word[i_idx]) begin
            o_pixel = WHITE_ARGB;
        end else begin
            o_pixel = BLACK_ARGB;
        end
    end

endmodule
